>>> rtl/uv_sphere_mesh_generator_assert.svh
// assertion macros for the uv sphere generator
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// implication checked at every clock edge outside reset
`define UVS_ASSERT_IMP(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("uvs assertion failed");

// next-cycle implication
`define UVS_ASSERT_NXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("uvs assertion failed");

`endif

>>> rtl/uvs_pkg.sv
package uvs_pkg;
	localparam int AngleBitsDef = 16;
	localparam int CordicIterDef = 16;
	localparam int IndexBits = 16;
	localparam int PosBits = 17;

	localparam logic [2:0] RegStacks = 3'd0;
	localparam logic [2:0] RegSlices = 3'd1;
	localparam logic [2:0] RegRadius = 3'd2;
	localparam logic [2:0] RegThetaStep = 3'd3;
	localparam logic [2:0] RegPhiStep = 3'd4;

	localparam logic signed [33:0] CordicGainInv = 34'sd652032874;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_VERT = 2'd1,
		PH_TRI  = 2'd2
	} gen_phase_t;

	// step sequencer states of the top level
	typedef enum logic [1:0] {
		TS_IDLE,
		TS_VERT,
		TS_TRI,
		TS_OUT
	} tstate_t;

	// sequencer states of the vertex datapath
	typedef enum logic [2:0] {
		VS_IDLE,
		VS_ROT,
		VS_MUL_Y,
		VS_MUL_T,
		VS_MUL_X,
		VS_MUL_Z,
		VS_DONE
	} vstate_t;

	// control between top and vertex unit
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} vctl_t;

	function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0: r = 34'sh20000000;
			5'd1: r = 34'sh12E4051E;
			5'd2: r = 34'sh09FB385B;
			5'd3: r = 34'sh051111D4;
			5'd4: r = 34'sh028B0D43;
			5'd5: r = 34'sh0145D7E1;
			5'd6: r = 34'sh00A2F61E;
			5'd7: r = 34'sh00517C55;
			5'd8: r = 34'sh0028BE53;
			5'd9: r = 34'sh00145F2F;
			5'd10: r = 34'sh000A2F98;
			5'd11: r = 34'sh000517CC;
			5'd12: r = 34'sh00028BE6;
			5'd13: r = 34'sh000145F3;
			5'd14: r = 34'sh0000A2FA;
			5'd15: r = 34'sh0000517D;
			5'd16: r = 34'sh000028BE;
			5'd17: r = 34'sh0000145F;
			5'd18: r = 34'sh00000A30;
			5'd19: r = 34'sh00000518;
			5'd20: r = 34'sh0000028C;
			5'd21: r = 34'sh00000146;
			5'd22: r = 34'sh000000A3;
			5'd23: r = 34'sh00000051;
			default: r = 34'sh0;
		endcase
		return r;
	endfunction

	// round half up by 2^15 then keep 17 bits (value known to fit)
	function automatic logic signed [16:0] rnd15(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd16384) >>> 15;
		return t[16:0];
	endfunction

	function automatic logic signed [16:0] sat17(input logic signed [47:0] v);
		logic signed [16:0] r;
		if (v > 48'sd65535) r = 17'sd65535;
		else if (v < -48'sd65536) r = -17'sd65536;
		else r = v[16:0];
		return r;
	endfunction
endpackage

>>> rtl/uv_sphere_mesh_generator.sv
// uv sphere mesh generator
// input channel s_axis: one item per step; tdata = {base_index, start_req}.
// start_req=1 latches base_index and restarts the sphere; start_req=0
// advances it. each accepted item gives zero or one result item.
// output channel m_axis: tdata = pos_x, pos_y, pos_z, index_a, index_b,
// index_c from the low bits up; tuser = kind (0 vertex, 1 triangle);
// tlast marks the final triangle of the sphere.
// config channel cfg: index 0 stacks, 1 slices, 2 radius, 3 theta step,
// 4 phi step; write only while idle.
// a vertex makes two cordic passes on one shared rotation engine, then
// forms pos_y, t, pos_x and pos_z in turn on one shared multiplier before
// its result is registered for output; a triangle is registered for
// output from the triangle state.
// the block takes one item at a time; s_axis_tready is low while an item
// is in work or its result waits in the output register.
// reset clears state to idle and the config registers to their defaults.
// a stalled receiver simply holds the output register and the input side.
module uv_sphere_mesh_generator import uvs_pkg::*; #(
	parameter int ANGLE_BITS = AngleBitsDef,
	parameter int CORDIC_ITERATIONS = CordicIterDef,
	parameter int INDEX_BITS = IndexBits
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [23:0]             s_axis_tdata,   // start_req, base_index
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [103:0]            m_axis_tdata,   // pos_x,pos_y,pos_z,index_a,index_b,index_c
	output logic                    m_axis_tuser,   // kind
	output logic                    m_axis_tlast,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data
);
	`include "uv_sphere_mesh_generator_assert.svh"

	localparam logic [ANGLE_BITS-1:0] PhiStart = {2'b11, {(ANGLE_BITS-2){1'b0}}};

	logic [7:0] stacks_q, slices_q;
	logic [15:0] radius_q, theta_step_q, phi_step_q;

	gen_phase_t phase_q;
	logic [7:0] row_q, col_q;
	logic [ANGLE_BITS-1:0] theta_q, phi_q;
	logic [INDEX_BITS-1:0] base_q;
	logic second_q;

	tstate_t ts_q, ts_d;

	logic in_fire, out_fire;
	logic start_req;
	logic [15:0] base_in;
	vctl_t vctl;
	logic v_start;
	logic signed [16:0] vx, vy, vz;
	logic [ANGLE_BITS-1:0] theta_adv, phi_inc;
	logic [INDEX_BITS-1:0] nb;
	logic tri_out_range;

	assign start_req = s_axis_tdata[0];
	assign base_in = s_axis_tdata[16:1];
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (ts_q == TS_IDLE);
	assign m_axis_tvalid = (ts_q == TS_OUT);
	assign cfg_ready = 1'b1;

	// counters pushed out of range by a register change end the sphere
	assign tri_out_range = (row_q >= stacks_q) || (col_q >= slices_q);

	// step to phase scaling
	if (ANGLE_BITS >= 16) begin : g_up
		assign theta_adv = ANGLE_BITS'(theta_step_q) << (ANGLE_BITS - 16);
		assign phi_inc = ANGLE_BITS'(phi_step_q) << (ANGLE_BITS - 16);
	end else begin : g_dn
		assign theta_adv = theta_step_q[15 -: ANGLE_BITS];
		assign phi_inc = phi_step_q[15 -: ANGLE_BITS];
	end

	assign nb = INDEX_BITS'(slices_q);

	uvs_vertex #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vertex (
		.clk(clk), .arst_n(arst_n), .start(v_start),
		.theta(theta_q), .phi(phi_q), .radius(radius_q),
		.ctl(vctl), .pos_x(vx), .pos_y(vy), .pos_z(vz)
	);

	assign v_start = (ts_q == TS_VERT) && !vctl.busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stacks_q <= 8'd16;
			slices_q <= 8'd16;
			radius_q <= 16'd256;
			theta_step_q <= 16'd4096;
			phi_step_q <= 16'd2048;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegStacks: stacks_q <= cfg_data[7:0];
				RegSlices: slices_q <= cfg_data[7:0];
				RegRadius: radius_q <= cfg_data;
				RegThetaStep: theta_step_q <= cfg_data;
				RegPhiStep: phi_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		ts_d = ts_q;
		case (ts_q)
			TS_IDLE: if (in_fire) begin
				if (start_req || phase_q == PH_VERT) ts_d = TS_VERT;
				else if (phase_q == PH_TRI) ts_d = TS_TRI;
			end
			TS_VERT: if (vctl.done) ts_d = TS_OUT;
			TS_TRI: if (tri_out_range) ts_d = TS_IDLE;
				else ts_d = TS_OUT;
			TS_OUT: if (out_fire) ts_d = TS_IDLE;
			default: ts_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ts_q <= TS_IDLE;
		else ts_q <= ts_d;
	end

	// step state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			row_q <= '0;
			col_q <= '0;
			theta_q <= '0;
			phi_q <= PhiStart;
			base_q <= '0;
			second_q <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tuser <= 1'b0;
			m_axis_tlast <= 1'b0;
		end else begin
			case (ts_q)
				TS_IDLE: if (in_fire) begin
					if (start_req) begin
						base_q <= base_in[INDEX_BITS-1:0];
						row_q <= '0;
						col_q <= '0;
						second_q <= 1'b0;
						theta_q <= '0;
						phi_q <= PhiStart;
						phase_q <= PH_VERT;
					end else if (phase_q != PH_VERT && phase_q != PH_TRI) phase_q <= PH_IDLE;
				end
				TS_VERT: if (vctl.done) begin
					m_axis_tdata <= {53'b0, vz, vy, vx};
					m_axis_tuser <= 1'b0;
					m_axis_tlast <= 1'b0;
					if (col_q >= slices_q) begin
						col_q <= '0;
						phi_q <= PhiStart;
						theta_q <= theta_q + theta_adv;
						if (row_q >= stacks_q) begin
							row_q <= '0;
							second_q <= 1'b0;
							phase_q <= (stacks_q == 8'd0 || slices_q == 8'd0) ? PH_IDLE : PH_TRI;
						end else row_q <= row_q + 8'd1;
					end else begin
						col_q <= col_q + 8'd1;
						phi_q <= phi_q + phi_inc;
					end
				end
				TS_TRI: begin
					if (tri_out_range) begin
						phase_q <= PH_IDLE;
					end else begin
						m_axis_tuser <= 1'b1;
						if (!second_q) begin
							m_axis_tdata <= {5'b0, 16'(base_q + nb + 1'b1),
								16'(base_q + 1'b1), 16'(base_q), 51'b0};
							m_axis_tlast <= 1'b0;
							second_q <= 1'b1;
						end else begin
							m_axis_tdata <= {5'b0, 16'(base_q + nb + 1'b1),
								16'(base_q + nb + 2'd2), 16'(base_q + 1'b1), 51'b0};
							m_axis_tlast <= (9'(col_q) + 9'd1 >= 9'(slices_q)) &&
								(9'(row_q) + 9'd1 >= 9'(stacks_q));
							second_q <= 1'b0;
							if (9'(col_q) + 9'd1 >= 9'(slices_q)) begin
								col_q <= '0;
								base_q <= base_q + 2'd2;
								row_q <= row_q + 8'd1;
							end else begin
								col_q <= col_q + 8'd1;
								base_q <= base_q + 1'b1;
							end
							if ((9'(col_q) + 9'd1 >= 9'(slices_q)) &&
								(9'(row_q) + 9'd1 >= 9'(stacks_q))) phase_q <= PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`UVS_ASSERT_IMP(a_no_accept_busy, clk, arst_n, ts_q != TS_IDLE, !s_axis_tready)
	`UVS_ASSERT_IMP(a_vertex_kind, clk, arst_n, m_axis_tvalid && !m_axis_tuser, !m_axis_tlast)
	`UVS_ASSERT_NXT(a_out_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule

>>> rtl/uvs_cordic.sv
// one cordic rotation engine, run twice per vertex (theta then phi)
module uvs_cordic import uvs_pkg::*; #(
	parameter int ANGLE_BITS = AngleBitsDef,
	parameter int CORDIC_ITERATIONS = CordicIterDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ANGLE_BITS-1:0]        phase,
	output logic                         done,
	output logic signed [16:0]           sin_q15,
	output logic signed [16:0]           cos_q15
);
	localparam int IterBits = $clog2(CORDIC_ITERATIONS + 1);

	logic signed [33:0] x_q, y_q, z_q;
	logic [1:0] quad_q;
	logic [IterBits-1:0] iter_q;
	logic run_q;
	logic done_q;
	logic [31:0] a32;
	logic signed [16:0] c, s;

	assign a32 = {phase, {(32 - ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			// one-cycle strobe when the last iteration completes, suppressed by start
			done_q <= !start && run_q && (iter_q == IterBits'(CORDIC_ITERATIONS - 1));
			if (start) begin
				run_q <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == IterBits'(CORDIC_ITERATIONS - 1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CordicGainInv;
			y_q <= '0;
			z_q <= $signed({4'b0, a32[29:0]});
			quad_q <= a32[31:30];
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> iter_q);
				y_q <= y_q + (x_q >>> iter_q);
				z_q <= z_q - atan_turn(5'(iter_q));
			end else begin
				x_q <= x_q + (y_q >>> iter_q);
				y_q <= y_q - (x_q >>> iter_q);
				z_q <= z_q + atan_turn(5'(iter_q));
			end
		end
	end

	assign done = done_q;
	assign c = rnd15(x_q);
	assign s = rnd15(y_q);

	always_comb begin
		case (quad_q)
			2'd0: begin cos_q15 = c; sin_q15 = s; end
			2'd1: begin cos_q15 = -s; sin_q15 = c; end
			2'd2: begin cos_q15 = -c; sin_q15 = -s; end
			default: begin cos_q15 = s; sin_q15 = -c; end
		endcase
	end
endmodule

>>> rtl/uvs_vertex.sv
// vertex datapath: cordic twice, then one shared multiplier four times
module uvs_vertex import uvs_pkg::*; #(
	parameter int ANGLE_BITS = AngleBitsDef,
	parameter int CORDIC_ITERATIONS = CordicIterDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ANGLE_BITS-1:0]   theta,
	input  logic [ANGLE_BITS-1:0]   phi,
	input  logic [15:0]             radius,
	output vctl_t                   ctl,
	output logic signed [16:0]      pos_x,
	output logic signed [16:0]      pos_y,
	output logic signed [16:0]      pos_z
);
	vstate_t st_q, st_d;
	logic second_q;
	logic c_start, c_done;
	logic signed [16:0] c_sin, c_cos;
	logic signed [16:0] st_q15_q, ct_q15_q, sp_q15_q, cp_q15_q;
	logic signed [33:0] t_q;
	logic signed [33:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [50:0] prod;
	logic signed [50:0] rnd30, rnd15v;

	// theta pass is started from idle, phi pass from the rotate state
	uvs_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start),
		.phase((st_q == VS_ROT) ? phi : theta),
		.done(c_done), .sin_q15(c_sin), .cos_q15(c_cos)
	);

	always_comb begin
		st_d = st_q;
		c_start = 1'b0;
		case (st_q)
			VS_IDLE: if (start) begin st_d = VS_ROT; c_start = 1'b1; end
			VS_ROT: if (c_done && second_q) st_d = VS_MUL_Y;
				else if (c_done) c_start = 1'b1;
			VS_MUL_Y: st_d = VS_MUL_T;
			VS_MUL_T: st_d = VS_MUL_X;
			VS_MUL_X: st_d = VS_MUL_Z;
			VS_MUL_Z: st_d = VS_DONE;
			VS_DONE: st_d = VS_IDLE;
			default: st_d = VS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= VS_IDLE;
			second_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == VS_IDLE) second_q <= 1'b0;
			else if (st_q == VS_ROT && c_done) second_q <= 1'b1;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = $signed({18'b0, radius});
		mul_b = sp_q15_q;
		case (st_q)
			VS_MUL_Y: begin mul_a = $signed({18'b0, radius}); mul_b = sp_q15_q; end
			VS_MUL_T: begin mul_a = $signed({18'b0, radius}); mul_b = cp_q15_q; end
			VS_MUL_X: begin mul_a = t_q; mul_b = ct_q15_q; end
			VS_MUL_Z: begin mul_a = t_q; mul_b = st_q15_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod = 51'(mul_a) * 51'(mul_b);
	assign rnd15v = (prod + 51'sd16384) >>> 15;
	assign rnd30 = (prod + 51'sd536870912) >>> 30;

	always_ff @(posedge clk) begin
		if (st_q == VS_ROT && c_done) begin
			if (second_q) begin sp_q15_q <= c_sin; cp_q15_q <= c_cos; end
			else begin st_q15_q <= c_sin; ct_q15_q <= c_cos; end
		end
		case (st_q)
			VS_MUL_Y: pos_y <= sat17(rnd15v[47:0]);
			VS_MUL_T: t_q <= prod[33:0];
			VS_MUL_X: pos_x <= sat17(rnd30[47:0]);
			VS_MUL_Z: pos_z <= sat17(rnd30[47:0]);
			default: ;
		endcase
	end

	assign ctl.start = start;
	assign ctl.busy = (st_q != VS_IDLE);
	assign ctl.done = (st_q == VS_DONE);
endmodule
